### hdl/sidx_pkg.sv
// Shared types and constants for the segment index box parser.
package sidx_pkg;

    localparam logic [1:0] KIND_ENTRY   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;

    localparam logic [3:0] POS_COUNT = 4'd7;
    localparam logic [3:0] POS_ENTRY = 4'd8;

    localparam logic [19:0] US_PER_S = 20'd1000000;

    localparam int QUOT_W = 64;
    localparam int CNT_W  = 7;

    typedef struct packed {
        logic [31:0] word;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] entry_size;
        logic [63:0] duration_us;
        logic        sub_index;
        logic        sap_ok;
        logic [31:0] reference_id;
        logic [31:0] time_scale;
        logic [63:0] earliest_time;
        logic [63:0] first_offset;
        logic [1:0]  status;
        logic        run_end;
    } out_item_t;

    // Divider request: dividend and divisor.
    typedef struct packed {
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

endpackage

### hdl/sidx_scale.sv
// Bit-serial multiply by one million (shift-add, one multiplier bit a cycle).
module sidx_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [63:0]         value,
    output logic                done,
    output logic [63:0]         product
);
    import sidx_pkg::*;

    logic [19:0] mult_reg, mult_next;
    logic [63:0] addend_reg, addend_next;
    logic [63:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        mult_next   = mult_reg;
        addend_next = addend_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mult_next   = US_PER_S;
            addend_next = value;
            acc_next    = '0;
            cnt_next    = 5'd0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mult_reg[0])
                acc_next = acc_reg + addend_reg;
            addend_next = {addend_reg[62:0], 1'b0};
            mult_next   = {1'b0, mult_reg[19:1]};
            cnt_next    = cnt_reg + 5'd1;
            if (cnt_reg == 5'd19)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg   <= mult_next;
        addend_reg <= addend_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

### hdl/sidx_div.sv
// Restoring bit-serial divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
module sidx_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sidx_pkg::div_req_t  req,
    output logic                done,
    output logic [63:0]         quotient
);
    import sidx_pkg::*;

    logic [63:0]     quo_reg, quo_next;
    logic [32:0]     rem_reg, rem_next;
    logic [31:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [32:0]     trial;
    logic [32:0]     shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[31:0], quo_reg[63]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### hdl/segment_index_box_parser.sv
// Top level of the segment index box parser.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  in      | in        | in_valid / in_stall  | sidx_pkg::in_item_t
//  out     | out       | out_valid / out_stall| sidx_pkg::out_item_t
//
// Header words are taken while the parser is idle. A reference entry's third
// word starts a serial multiply by one million and then a serial divide; the
// summary needs another multiply and divide. The parser takes no new word
// until these finish. Reset clears the parser state but not the entry's SAP
// flag or the result register. One result register sits at the output; a
// stalled result holds, and the parser takes no new word until every result
// of the current word is gone.
module segment_index_box_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sidx_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sidx_pkg::out_item_t  out_data
);
    import sidx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ENT_MUL, S_ENT_DIV, S_ENT_OUT,
        S_SUM_START, S_SUM_MUL, S_SUM_DIV, S_SUM_OUT, S_ERR_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  ver_reg, ver_next;
    logic [31:0] ref_id_reg, ref_id_next;
    logic [31:0] scale_reg, scale_next;
    logic [63:0] pres_reg, pres_next;
    logic [63:0] offs_reg, offs_next;
    logic [15:0] left_reg, left_next;
    logic [31:0] size_w_reg, size_w_next;
    logic [31:0] dur_w_reg, dur_w_next;
    logic [47:0] sum_reg, sum_next;
    logic        done_reg, done_next;
    logic        last_reg, last_next;      // word in flight had last_word
    logic        sap_reg, sap_next;
    logic        ovalid_reg, ovalid_next;
    out_item_t   out_reg, out_next;

    logic        mul_start, mul_done;
    logic [63:0] mul_value, mul_prod;
    logic        div_start, div_done;
    div_req_t    div_req;
    logic [63:0] div_quo;
    logic        take, out_free;
    logic [2:0]  sap_type;
    out_item_t   blank;

    sidx_scale u_scale (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .value(mul_value),
        .done(mul_done), .product(mul_prod)
    );

    sidx_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .req(div_req),
        .done(div_done), .quotient(div_quo)
    );

    assign out_free  = !ovalid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign take      = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;
    assign sap_type  = in_data.word[30:28];

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        ver_next    = ver_reg;
        ref_id_next = ref_id_reg;
        scale_next  = scale_reg;
        pres_next   = pres_reg;
        offs_next   = offs_reg;
        left_next   = left_reg;
        size_w_next = size_w_reg;
        dur_w_next  = dur_w_reg;
        sum_next    = sum_reg;
        done_next   = done_reg;
        last_next   = last_reg;
        sap_next    = sap_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg && out_stall;
        mul_start   = 1'b0;
        mul_value   = {32'd0, dur_w_reg};
        div_start   = 1'b0;
        div_req.dividend = mul_prod;
        div_req.divisor  = scale_reg;
        blank       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    last_next = in_data.last_word;
                    if (!done_reg)
                    begin
                        unique case (pos_reg)
                            4'd0:
                            begin
                                ver_next = in_data.word[31:24];
                                pos_next = 4'd1;
                            end
                            4'd1:
                            begin
                                ref_id_next = in_data.word;
                                pos_next    = 4'd2;
                            end
                            4'd2:
                            begin
                                scale_next = in_data.word;
                                pos_next   = 4'd3;
                            end
                            4'd3:
                            begin
                                pres_next = (ver_reg == 8'd0) ? {32'd0, in_data.word}
                                                              : {in_data.word, 32'd0};
                                pos_next  = 4'd4;
                            end
                            4'd4:
                            begin
                                if (ver_reg == 8'd0)
                                begin
                                    offs_next = {32'd0, in_data.word};
                                    pos_next  = POS_COUNT;
                                end
                                else
                                begin
                                    pres_next = {pres_reg[63:32], in_data.word};
                                    pos_next  = 4'd5;
                                end
                            end
                            4'd5:
                            begin
                                offs_next = {in_data.word, 32'd0};
                                pos_next  = 4'd6;
                            end
                            4'd6:
                            begin
                                offs_next = {offs_reg[63:32], in_data.word};
                                pos_next  = POS_COUNT;
                            end
                            POS_COUNT:
                            begin
                                left_next = in_data.word[15:0];
                                if (in_data.word[15:0] == 16'd0)
                                    state_next = S_SUM_START;
                                else
                                    pos_next = POS_ENTRY;
                            end
                            POS_ENTRY:
                            begin
                                size_w_next = in_data.word;
                                pos_next    = POS_ENTRY + 4'd1;
                            end
                            POS_ENTRY + 4'd1:
                            begin
                                dur_w_next = in_data.word;
                                pos_next   = POS_ENTRY + 4'd2;
                            end
                            default:
                            begin
                                sap_next  = in_data.word[31] &&
                                            (sap_type == 3'd1 || sap_type == 3'd2);
                                mul_start = 1'b1;
                                state_next = S_ENT_MUL;
                            end
                        endcase
                    end
                    else if (in_data.last_word)
                    begin
                        // Trailing words end: restart quietly.
                        pos_next  = '0; ver_next = '0; ref_id_next = '0;
                        scale_next = '0; pres_next = '0; offs_next = '0;
                        left_next = '0; size_w_next = '0; dur_w_next = '0;
                        sum_next  = '0; done_next = 1'b0;
                    end
                    if (!done_reg && in_data.last_word && pos_reg != POS_COUNT
                        && pos_reg < POS_ENTRY + 4'd2)
                        state_next = S_ERR_OUT;
                    else if (!done_reg && in_data.last_word && pos_reg == POS_COUNT
                             && in_data.word[15:0] != 16'd0)
                        state_next = S_ERR_OUT;
                end
            end
            S_ENT_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_ENT_DIV;
                end
            end
            S_ENT_DIV:
            begin
                if (div_done)
                    state_next = S_ENT_OUT;
            end
            S_ENT_OUT:
            begin
                if (out_free)
                begin
                    out_next            = blank;
                    out_next.kind       = KIND_ENTRY;
                    out_next.entry_size = size_w_reg[30:0];
                    out_next.sub_index  = size_w_reg[31];
                    out_next.sap_ok     = sap_reg;
                    if (scale_reg == 32'd0)
                        out_next.status = STATUS_ZERO;
                    else
                        out_next.duration_us = div_quo;
                    ovalid_next = 1'b1;
                    sum_next    = sum_reg + {16'd0, dur_w_reg};
                    left_next   = left_reg - 16'd1;
                    if (left_reg == 16'd1)
                        state_next = S_SUM_START;
                    else
                    begin
                        pos_next = POS_ENTRY;
                        if (last_reg)
                            state_next = S_ERR_OUT;
                        else
                        begin
                            state_next = S_IDLE;
                            out_next.run_end = 1'b1;
                        end
                    end
                end
            end
            S_SUM_START:
            begin
                mul_value  = {16'd0, sum_reg};
                mul_start  = 1'b1;
                state_next = S_SUM_MUL;
            end
            S_SUM_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_SUM_DIV;
                end
            end
            S_SUM_DIV:
            begin
                if (div_done)
                    state_next = S_SUM_OUT;
            end
            S_SUM_OUT:
            begin
                if (out_free)
                begin
                    out_next               = blank;
                    out_next.reference_id  = ref_id_reg;
                    out_next.time_scale    = scale_reg;
                    out_next.earliest_time = pres_reg;
                    out_next.first_offset  = offs_reg;
                    out_next.run_end       = 1'b1;
                    if (scale_reg == 32'd0)
                    begin
                        out_next.kind   = KIND_ERROR;
                        out_next.status = STATUS_ZERO;
                    end
                    else
                    begin
                        out_next.kind        = KIND_SUMMARY;
                        out_next.duration_us = div_quo;
                    end
                    ovalid_next = 1'b1;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    if (last_reg)
                    begin
                        // Box closes on its last word: restart.
                        pos_next  = '0; ver_next = '0; ref_id_next = '0;
                        scale_next = '0; pres_next = '0; offs_next = '0;
                        left_next = '0; size_w_next = '0; dur_w_next = '0;
                        sum_next  = '0; done_next = 1'b0;
                    end
                end
            end
            S_ERR_OUT:
            begin
                if (out_free)
                begin
                    out_next         = blank;
                    out_next.kind    = KIND_ERROR;
                    out_next.status  = STATUS_SHORT;
                    out_next.run_end = 1'b1;
                    ovalid_next      = 1'b1;
                    state_next       = S_IDLE;
                    pos_next  = '0; ver_next = '0; ref_id_next = '0;
                    scale_next = '0; pres_next = '0; offs_next = '0;
                    left_next = '0; size_w_next = '0; dur_w_next = '0;
                    sum_next  = '0; done_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            ver_reg    <= '0;
            ref_id_reg <= '0;
            scale_reg  <= '0;
            pres_reg   <= '0;
            offs_reg   <= '0;
            left_reg   <= '0;
            size_w_reg <= '0;
            dur_w_reg  <= '0;
            sum_reg    <= '0;
            done_reg   <= 1'b0;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            ver_reg    <= ver_next;
            ref_id_reg <= ref_id_next;
            scale_reg  <= scale_next;
            pres_reg   <= pres_next;
            offs_reg   <= offs_next;
            left_reg   <= left_next;
            size_w_reg <= size_w_next;
            dur_w_reg  <= dur_w_next;
            sum_reg    <= sum_next;
            done_reg   <= done_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sap_reg <= sap_next;
        out_reg <= out_next;
    end
endmodule

### tb/testbench.sv
// Self-checking testbench for the segment index box parser.
`timescale 1ns / 1ps

module testbench;

    import sidx_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;

    segment_index_box_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Clock: 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow copy of the parser state.
    logic [3:0]  pos_q;
    logic [7:0]  version_q;
    logic [31:0] refid_q;
    logic [31:0] scale_q;
    logic [63:0] early_q;
    logic [63:0] offs_q;
    logic [15:0] left_q;
    logic [31:0] size_word_q;
    logic [31:0] dur_word_q;
    logic [47:0] dur_sum_q;
    logic        done_q;

    in_item_t  word_queue[$];      // words still to be driven
    out_item_t expected_items[$];  // results still to arrive
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_send;

    task automatic clear_box();
    begin
        pos_q = 4'd0;
        version_q = 8'd0;
        refid_q = 32'd0;
        scale_q = 32'd0;
        early_q = 64'd0;
        offs_q = 64'd0;
        left_q = 16'd0;
        size_word_q = 32'd0;
        dur_word_q = 32'd0;
        dur_sum_q = 48'd0;
        done_q = 1'b0;
    end
    endtask

    function automatic out_item_t box_summary();
        out_item_t r;
        logic [63:0] total;
        r = '0;
        r.reference_id = refid_q;
        r.time_scale = scale_q;
        r.earliest_time = early_q;
        r.first_offset = offs_q;
        if (scale_q == 32'd0)
        begin
            r.kind = KIND_ERROR;
            r.status = STATUS_ZERO;
        end
        else
        begin
            // Product wraps at 64 bits before the divide.
            total = {16'd0, dur_sum_q} * 64'd1000000;
            r.kind = KIND_SUMMARY;
            r.duration_us = total / {32'd0, scale_q};
        end
        return r;
    endfunction

    // Advance the shadow parser by one word and queue what it emits.
    task automatic parse_word(input in_item_t it);
        out_item_t res[$];
        out_item_t r;
        logic [2:0] sap_type;
        logic [31:0] w;
    begin
        w = it.word;
        if (!done_q)
        begin
            case (pos_q)
                4'd0: begin version_q = w[31:24]; pos_q = 4'd1; end
                4'd1: begin refid_q = w; pos_q = 4'd2; end
                4'd2: begin scale_q = w; pos_q = 4'd3; end
                4'd3:
                begin
                    early_q = (version_q == 8'd0) ? {32'd0, w} : {w, 32'd0};
                    pos_q = 4'd4;
                end
                4'd4:
                begin
                    if (version_q == 8'd0)
                    begin
                        offs_q = {32'd0, w};
                        pos_q = POS_COUNT;
                    end
                    else
                    begin
                        early_q[31:0] = w;
                        pos_q = 4'd5;
                    end
                end
                4'd5: begin offs_q = {w, 32'd0}; pos_q = 4'd6; end
                4'd6: begin offs_q[31:0] = w; pos_q = POS_COUNT; end
                POS_COUNT:
                begin
                    left_q = w[15:0];
                    if (left_q == 16'd0)
                    begin
                        res.push_back(box_summary());
                        done_q = 1'b1;
                    end
                    else
                        pos_q = POS_ENTRY;
                end
                POS_ENTRY: begin size_word_q = w; pos_q = POS_ENTRY + 4'd1; end
                POS_ENTRY + 4'd1: begin dur_word_q = w; pos_q = POS_ENTRY + 4'd2; end
                default:
                begin
                    sap_type = w[30:28];
                    r = '0;
                    r.kind = KIND_ENTRY;
                    r.entry_size = size_word_q[30:0];
                    r.sub_index = size_word_q[31];
                    r.sap_ok = w[31] && (sap_type == 3'd1 || sap_type == 3'd2);
                    if (scale_q == 32'd0)
                        r.status = STATUS_ZERO;
                    else
                        r.duration_us = ({32'd0, dur_word_q} * 64'd1000000)
                                        / {32'd0, scale_q};
                    res.push_back(r);
                    dur_sum_q = dur_sum_q + {16'd0, dur_word_q};
                    left_q = left_q - 16'd1;
                    if (left_q == 16'd0)
                    begin
                        res.push_back(box_summary());
                        done_q = 1'b1;
                    end
                    else
                        pos_q = POS_ENTRY;
                end
            endcase
        end
        if (it.last_word)
        begin
            if (!done_q)
            begin
                r = '0;
                r.kind = KIND_ERROR;
                r.status = STATUS_SHORT;
                res.push_back(r);
            end
            clear_box();
        end
        if (res.size() > 0)
            res[res.size() - 1].run_end = 1'b1;
        foreach (res[i])
            expected_items.push_back(res[i]);
    end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 20);
            default: return $urandom;
        endcase
    endfunction

    // Queue one box. words_cut < 0 sends it whole; trail adds ignored words to an uncut box.
    task automatic queue_box(input logic [31:0] version_word, input logic [31:0] scale,
                             input int refs, input int words_cut, input int trail);
        logic [31:0] ws[$];
        logic [31:0] w;
        int n;
        in_item_t it;
    begin
        ws.push_back(version_word);
        ws.push_back(rand_word());
        ws.push_back(scale);
        n = (version_word[31:24] == 8'd0) ? 2 : 4;
        repeat (n) ws.push_back(rand_word());
        w = $urandom;
        w[15:0] = refs[15:0];
        ws.push_back(w);
        repeat (refs)
        begin
            ws.push_back(rand_word());
            ws.push_back(rand_word());
            w = $urandom;
            if ($urandom_range(0, 1))
                w[30:28] = $urandom_range(1, 2);
            ws.push_back(w);
        end
        if (words_cut >= 0 && words_cut < ws.size())
            ws = ws[0:words_cut];
        else
            repeat (trail) ws.push_back($urandom);
        foreach (ws[i])
        begin
            it.word = ws[i];
            it.last_word = (i == ws.size() - 1);
            word_queue.push_back(it);
        end
    end
    endtask

    task automatic drain();
    begin
        while (word_queue.size() > 0 || expected_items.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    end
    endtask

    // Driver: hold payload while stalled, drop idles at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                parse_word(in_data);
                void'(word_queue.pop_front());
            end
            if (!in_valid || !in_stall)
            begin
                if (word_queue.size() > (in_valid && !in_stall ? 0 : 0) && !hold_send
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= word_queue[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_items.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %p", out_data);
                end
                else
                begin
                    if (out_data !== expected_items[0])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch\n  expected %p\n  actual   %p",
                                     expected_items[0], out_data);
                    end
                    void'(expected_items.pop_front());
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // The driver pops the queue only on acceptance, so the front stays the
    // word on the bus; word_queue[0] is re-presented each idle cycle.

    initial
    begin
        rst_n = 1'b0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        clear_box();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: both versions, zero count, zero timescale, truncation,
        // trailing words and extreme field values.
        queue_box(32'h0000_0000, 32'd1000, 0, -1, 0);
        queue_box(32'h0100_0000, 32'hFFFF_FFFF, 2, -1, 2);
        queue_box(32'hFF00_0000, 32'd0, 1, -1, 0);
        queue_box(32'h0000_0000, 32'd1, 2, 12, 0);
        queue_box(32'h0000_0000, 32'd90000, 1, 2, 0);
        drain();

        // hold_send is raised only while the box is queued, with no wait between, so the sender never pauses here.
        hold_send = 1'b1;
        queue_box(32'h0000_00FF, 32'd48000, 1, -1, 1);
        hold_send = 1'b0;
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                3: begin send_idle_pct = 12; recv_stall_pct = 12; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int b = 0; b < 7; b++)
            begin
                if ($urandom_range(0, 9) < 8)
                    queue_box({$urandom_range(0, 1) ? 8'd0 : 8'($urandom), 24'($urandom)},
                              ($urandom_range(0, 9) == 0) ? 32'd0 : rand_word(),
                              $urandom_range(0, 3), -1, $urandom_range(0, 2));
                else
                    queue_box($urandom, rand_word(), $urandom_range(1, 3),
                              $urandom_range(0, 15), 0);
            end
            drain();
        end

        if (mismatch_count == 0 && expected_items.size() == 0)
            $display("PASS segment_index_box_parser");
        else
            $display("FAIL segment_index_box_parser");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("FAIL segment_index_box_parser");
        $finish;
    end

endmodule
